// ----- hdl/pts_pkg.sv -----
// shared constants and types for the priority tick scheduler
package pts_pkg;

  localparam int MaxProcs = 16;
  localparam int SlotW    = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int CntW     = $clog2(MaxProcs + 1);

  localparam logic KindLoad = 1'b0;
  localparam logic KindTick = 1'b1;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } pts_entry_t;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] waddr;
    pts_entry_t       wdata;
    logic             re;
    logic [SlotW-1:0] raddr;
  } pts_tbl_req_t;

endpackage

// ----- hdl/priority_tick_scheduler.sv -----
// preemptive priority scheduler, one time unit per tick transaction
//
// input channel (valid/ready): kind_i = 0 appends a process entry (arrival,
// burst, priority) and gives no result; kind_i = 1 runs one time unit.
// output channel (valid/ready): one result transaction per tick, carrying the
// chosen slot or an idle flag, the completion figures when the process
// finished, the saturating totals and the all-done flag.
// a load fills the next table slot unless the table is full. a tick
// scans the process table through one synchronous memory read port, one
// entry per cycle, then passes through the update, stats, wait and total
// states to the result register; the next transaction is accepted once
// the result has been placed in the output register.
// the output register holds a result until it is taken; while the receiver
// stalls, the next tick is still accepted and computed, then waits in its
// last state until the register frees, and nothing is accepted behind it.
// reset clears time, counters and totals; the table needs no clearing since
// only slots below the loaded count are ever read.
module priority_tick_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] burst_length_i,
  input  logic [7:0]  prio_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        idle_tick_o,
  output logic [3:0]  proc_slot_o,
  output logic        finished_o,
  output logic [31:0] completion_time_o,
  output logic [31:0] turnaround_time_o,
  output logic [31:0] waiting_time_o,
  output logic [31:0] total_turnaround_o,
  output logic [31:0] total_waiting_o,
  output logic        all_done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_STATS,
    ST_WAIT,
    ST_TOTAL,
    ST_RESULT
  } state_e;

  localparam logic [pts_pkg::CntW-1:0] Full = pts_pkg::CntW'(pts_pkg::MaxProcs);

  state_e                      state_q;
  logic [pts_pkg::CntW-1:0]    loaded_q, done_q, scan_idx_q;
  logic                        cmp_vld_q;
  logic [pts_pkg::SlotW-1:0]   cmp_slot_q, pick_q;
  logic                        found_q, fin_q;
  pts_pkg::pts_entry_t         best_q;
  logic [31:0]                 now_q, sum_tat_q, sum_wt_q, tat_q, wt_q;

  logic                        out_valid_q, idle_q, fin_out_q, all_done_q;
  logic [3:0]                  slot_out_q;
  logic [31:0]                 ct_out_q, tat_out_q, wt_out_q;
  logic [31:0]                 tot_tat_out_q, tot_wt_out_q;

  pts_pkg::pts_tbl_req_t       tbl_req;
  pts_pkg::pts_entry_t         tbl_rdata;
  logic                        in_acc, scan_issue, cand_ok;
  logic [32:0]                 sum_tat_ext, sum_wt_ext;

  pts_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign scan_issue = (state_q == ST_SCAN) && (scan_idx_q < loaded_q);

  // entry read back this cycle is ready and beats the best so far
  assign cand_ok = ({16'd0, tbl_rdata.arrival} <= now_q) && (tbl_rdata.remaining != 16'd0)
                   && (!found_q || (tbl_rdata.prio > best_q.prio));

  assign sum_tat_ext = {1'b0, sum_tat_q} + {1'b0, tat_q};
  assign sum_wt_ext  = {1'b0, sum_wt_q} + {1'b0, wt_q};

  always_comb begin
    tbl_req       = '0;
    tbl_req.re    = scan_issue;
    tbl_req.raddr = scan_idx_q[pts_pkg::SlotW-1:0];
    if (in_acc && (kind_i == pts_pkg::KindLoad) && (loaded_q < Full)) begin
      tbl_req.we                = 1'b1;
      tbl_req.waddr             = loaded_q[pts_pkg::SlotW-1:0];
      tbl_req.wdata.arrival     = arrival_time_i;
      tbl_req.wdata.burst       = burst_length_i;
      tbl_req.wdata.prio        = prio_level_i;
      tbl_req.wdata.remaining   = burst_length_i;
    end else if ((state_q == ST_UPDATE) && found_q) begin
      tbl_req.we                = 1'b1;
      tbl_req.waddr             = pick_q;
      tbl_req.wdata             = best_q;
      tbl_req.wdata.remaining   = best_q.remaining - 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      loaded_q    <= '0;
      done_q      <= '0;
      scan_idx_q  <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      fin_q       <= 1'b0;
      now_q       <= '0;
      sum_tat_q   <= '0;
      sum_wt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (kind_i == pts_pkg::KindLoad) begin
              if (loaded_q < Full) begin
                loaded_q <= loaded_q + 1'b1;
                if (burst_length_i == 16'd0) begin
                  done_q <= done_q + 1'b1;
                end
              end
            end else begin
              scan_idx_q <= '0;
              cmp_vld_q  <= 1'b0;
              found_q    <= 1'b0;
              state_q    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cmp_vld_q  <= scan_issue;
          cmp_slot_q <= scan_idx_q[pts_pkg::SlotW-1:0];
          if (scan_issue) begin
            scan_idx_q <= scan_idx_q + 1'b1;
          end
          if (cmp_vld_q && cand_ok) begin
            found_q <= 1'b1;
            best_q  <= tbl_rdata;
            pick_q  <= cmp_slot_q;
          end
          if (!scan_issue && !cmp_vld_q) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (now_q != 32'hFFFF_FFFF) begin
            now_q <= now_q + 32'd1;
          end
          fin_q <= found_q && (best_q.remaining == 16'd1);
          if (found_q && (best_q.remaining == 16'd1)) begin
            done_q <= done_q + 1'b1;
          end
          state_q <= ST_STATS;
        end
        ST_STATS: begin
          tat_q   <= fin_q ? (now_q - {16'd0, best_q.arrival}) : 32'd0;
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          // waiting time floors at zero once time has saturated
          wt_q    <= (fin_q && (tat_q >= {16'd0, best_q.burst}))
                     ? (tat_q - {16'd0, best_q.burst}) : 32'd0;
          state_q <= ST_TOTAL;
        end
        ST_TOTAL: begin
          sum_tat_q <= sum_tat_ext[32] ? 32'hFFFF_FFFF : sum_tat_ext[31:0];
          sum_wt_q  <= sum_wt_ext[32] ? 32'hFFFF_FFFF : sum_wt_ext[31:0];
          state_q   <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            idle_q        <= !found_q;
            slot_out_q    <= found_q ? 4'(pick_q) : 4'd0;
            fin_out_q     <= fin_q;
            ct_out_q      <= fin_q ? now_q : 32'd0;
            tat_out_q     <= tat_q;
            wt_out_q      <= wt_q;
            tot_tat_out_q <= sum_tat_q;
            tot_wt_out_q  <= sum_wt_q;
            all_done_q    <= (done_q == loaded_q);
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign idle_tick_o        = idle_q;
  assign proc_slot_o        = slot_out_q;
  assign finished_o         = fin_out_q;
  assign completion_time_o  = ct_out_q;
  assign turnaround_time_o  = tat_out_q;
  assign waiting_time_o     = wt_out_q;
  assign total_turnaround_o = tot_tat_out_q;
  assign total_waiting_o    = tot_wt_out_q;
  assign all_done_o         = all_done_q;

endmodule

// ----- hdl/pts_table.sv -----
// process table memory: one write port, one registered read port
module pts_table (
  input  logic                  clk_i,
  input  pts_pkg::pts_tbl_req_t req_i,
  output pts_pkg::pts_entry_t   rdata_o
);

  pts_pkg::pts_entry_t mem_q [pts_pkg::MaxProcs];
  pts_pkg::pts_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
